/* hw/rtl/branch_direction_predictor_defines.svh */
// ----------------------------------------------------------------------------
// Branch direction predictor assertion macros
// Shared property shapes, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH
`define BRANCH_DIRECTION_PREDICTOR_DEFINES_SVH

// same-cycle implication
`define BDP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("branch predictor check failed");

// next-cycle implication
`define BDP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("branch predictor check failed");

`endif

/* hw/rtl/bdp_pkg.sv */
// ----------------------------------------------------------------------------
// bdp_pkg
// Constants and codes shared by the branch direction predictor files.
// ----------------------------------------------------------------------------
package bdp_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int PC_W              = 32;
   localparam int PC_SHIFT          = 3;
   localparam int KEY_W             = PC_W - PC_SHIFT;
   localparam int ENTRY_W           = 2;
   localparam int MODE_W            = 2;
   localparam int SQUASH_W          = 32;
   localparam int REQ_W             = 40;
   localparam int RSP_W             = 40;

   localparam logic [SQUASH_W-1:0] SQUASH_PER_MISS = SQUASH_W'(3);
   localparam logic [SQUASH_W-1:0] SQUASH_MAX      = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_STATIC  = 2'd0,
      MODE_ONE_BIT = 2'd1,
      MODE_TWO_BIT = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef logic [ENTRY_W-1:0] entry_type;

   localparam entry_type HIST_S0 = 2'd0;
   localparam entry_type HIST_S1 = 2'd1;
   localparam entry_type HIST_S2 = 2'd2;
   localparam entry_type HIST_S3 = 2'd3;

endpackage

/* hw/rtl/branch_direction_predictor.sv */
// ----------------------------------------------------------------------------
// Branch direction predictor
// Bimodal history table updated at most once per resolved branch; reports the
// prediction, a miss flag and a saturating squash total.
//
//   channel   dir   handshake            word
//   req_      in    tvalid / tready      branch_pc, was_taken
//   rsp_      out   tvalid / tready      predicted_taken, mispredicted, squash_total
//   csr_      in    wr_en                predictor_mode
//
// One word per cycle sustained while rsp_ does not stall; a taken request word is
// registered, then passes reciprocal multiply, remainder and table read, update.
// Reset clears the history valid bits, so every entry reads as zero at once;
// no clearing pass over the table.
// A stalled rsp_ side holds the pipeline back stage by stage; req_tready
// stays high while any stage is free.
// ----------------------------------------------------------------------------
`include "branch_direction_predictor_defines.svh"

module branch_direction_predictor #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // [31:0] branch_pc, [32] was_taken, [39:33] zero
   input  logic [bdp_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [0] predicted_taken, [1] mispredicted, [33:2] squash_total, [39:34] zero
   output logic [bdp_pkg::RSP_W-1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_wr_en,
   input  logic [bdp_pkg::MODE_W-1:0] csr_wr_data
);
   import bdp_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int PROD_W = 2 * KEY_W;
   localparam logic [KEY_W-1:0] N_KEY = KEY_W'(TABLE_ENTRIES);
   localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_ENTRIES);

   // control
   mode_type                 mode_ff, mode_in;
   logic [SQUASH_W-1:0]      squash_ff, squash_in;
   logic [TABLE_ENTRIES-1:0] vld_ff, vld_in;
   logic                     s0_valid_ff, s0_valid_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s2_valid_ff, s2_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic [KEY_W-1:0]         s0_key_ff, s0_key_in;
   logic                     s0_taken_ff, s0_taken_in;
   logic [KEY_W-1:0]         s1_key_ff, s1_key_in;
   logic [KEY_W-1:0]         s1_quot_ff, s1_quot_in;
   logic                     s1_taken_ff, s1_taken_in;
   logic [IDX_W-1:0]         s2_idx_ff, s2_idx_in;
   logic                     s2_taken_ff, s2_taken_in;
   logic                     fwd_ff, fwd_in;
   entry_type                fwd_data_ff, fwd_data_in;
   logic                     vld_rd_ff, vld_rd_in;
   logic                     rsp_pred_ff, rsp_pred_in;
   logic                     rsp_miss_ff, rsp_miss_in;

   logic                     out_free, s2_free, s1_free;
   logic                     s0_mv, s1_mv, s2_mv, req_acc;
   logic [PROD_W-1:0]        quot_prod;
   logic [KEY_W-1:0]         back_prod, rem_raw, rem_fix;
   logic [IDX_W-1:0]         idx1;
   entry_type                ram_rdata, entry, s2_new;
   logic                     s2_pred, s2_miss, s2_wr;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_mv      = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_mv      = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s0_mv      = s0_valid_ff && s1_free;
   assign req_tready = !s0_valid_ff || s1_free;
   assign req_acc    = req_tvalid && req_tready;

   // index = key mod TABLE_ENTRIES by reciprocal and one correction
   assign quot_prod = PROD_W'(s0_key_ff) * PROD_W'(RECIP);
   assign back_prod = s1_quot_ff * N_KEY;
   assign rem_raw   = s1_key_ff - back_prod;
   assign rem_fix   = (rem_raw >= N_KEY) ? (rem_raw - N_KEY) : rem_raw;
   assign idx1      = rem_fix[IDX_W-1:0];

   bdp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_hist (
      .clock   (clock),
      .wr_en   (s2_mv && s2_wr),
      .wr_addr (s2_idx_ff),
      .wr_data (s2_new),
      .rd_en   (s1_mv),
      .rd_addr (idx1),
      .rd_data (ram_rdata)
   );

   always_comb begin
      entry   = fwd_ff ? fwd_data_ff : (vld_rd_ff ? ram_rdata : HIST_S0);
      s2_pred = 1'b0;
      s2_miss = 1'b0;
      s2_wr   = 1'b0;
      s2_new  = HIST_S0;
      case (mode_ff)
         MODE_STATIC: begin
            s2_miss = s2_taken_ff;
         end
         MODE_ONE_BIT: begin
            if (entry == HIST_S0 || entry == HIST_S1) begin
               s2_pred = (entry == HIST_S1);
               s2_miss = s2_pred ^ s2_taken_ff;
               s2_wr   = 1'b1;
               s2_new  = s2_taken_ff ? HIST_S1 : HIST_S0;
            end
         end
         MODE_TWO_BIT: begin
            s2_pred = entry[1];
            s2_miss = s2_pred ^ s2_taken_ff;
            s2_wr   = 1'b1;
            if (s2_taken_ff) begin
               s2_new = (entry == HIST_S0) ? HIST_S1 : HIST_S3;
            end else begin
               s2_new = (entry == HIST_S3) ? HIST_S2 : HIST_S0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mode_in      = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;
      squash_in    = squash_ff;
      vld_in       = vld_ff;
      s0_valid_in  = req_acc || (s0_valid_ff && !s1_free);
      s1_valid_in  = s0_mv || (s1_valid_ff && !s2_free);
      s2_valid_in  = s1_mv || (s2_valid_ff && !out_free);
      rsp_valid_in = s2_mv || (rsp_valid_ff && !rsp_tready);
      s0_key_in    = req_acc ? req_tdata[PC_W-1:PC_SHIFT] : s0_key_ff;
      s0_taken_in  = req_acc ? req_tdata[PC_W] : s0_taken_ff;
      s1_key_in    = s0_mv ? s0_key_ff : s1_key_ff;
      s1_quot_in   = s0_mv ? quot_prod[PROD_W-1:KEY_W] : s1_quot_ff;
      s1_taken_in  = s0_mv ? s0_taken_ff : s1_taken_ff;
      s2_idx_in    = s2_idx_ff;
      s2_taken_in  = s2_taken_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      vld_rd_in    = vld_rd_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_miss_in  = rsp_miss_ff;
      if (s1_mv) begin
         s2_idx_in   = idx1;
         s2_taken_in = s1_taken_ff;
         fwd_in      = s2_mv && s2_wr && (s2_idx_ff == idx1);
         fwd_data_in = s2_new;
         vld_rd_in   = vld_ff[idx1];
      end
      if (s2_mv) begin
         rsp_pred_in = s2_pred;
         rsp_miss_in = s2_miss;
         if (s2_wr) begin
            vld_in[s2_idx_ff] = 1'b1;
         end
         if (s2_miss) begin
            squash_in = (squash_ff > (SQUASH_MAX - SQUASH_PER_MISS)) ? SQUASH_MAX
                                                                     : squash_ff + SQUASH_PER_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STATIC;
         squash_ff    <= '0;
         vld_ff       <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         squash_ff    <= squash_in;
         vld_ff       <= vld_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s0_key_ff   <= s0_key_in;
      s0_taken_ff <= s0_taken_in;
      s1_key_ff   <= s1_key_in;
      s1_quot_ff  <= s1_quot_in;
      s1_taken_ff <= s1_taken_in;
      s2_idx_ff   <= s2_idx_in;
      s2_taken_ff <= s2_taken_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      vld_rd_ff   <= vld_rd_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - SQUASH_W - 2)'(0), squash_ff, rsp_miss_ff, rsp_pred_ff};

   `BDP_ASSERT_NEXT(a_squash_monotonic, 1'b1, squash_ff >= $past(squash_ff))
   `BDP_ASSERT_NEXT(a_squash_on_miss, s2_mv && s2_miss,
                    (squash_ff != $past(squash_ff)) || (squash_ff == SQUASH_MAX))
   `BDP_ASSERT_IMPLY(a_miss_counted, rsp_valid_ff && rsp_miss_ff, squash_ff != '0)

endmodule

/* hw/rtl/bdp_ram.sv */
// ----------------------------------------------------------------------------
// bdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdp_ram #(
   parameter int WIDTH = bdp_pkg::ENTRY_W,
   parameter int DEPTH = bdp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import bdp_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
